/* rtl/suffix_automaton_build_match_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the suffix automaton block.
// ----------------------------------------------------------------------------
`ifndef SUFFIX_AUTOMATON_BUILD_MATCH_ASSERT_SVH
`define SUFFIX_AUTOMATON_BUILD_MATCH_ASSERT_SVH

// A property that must hold at every rising clock edge outside reset.
`define SABM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// An implication checked on the next clock edge outside reset.
`define SABM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sabm_pkg.sv */
// ----------------------------------------------------------------------------
// sabm_pkg
// Types, codes and constants shared by the suffix automaton modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sabm_pkg;

  // Default text capacity in symbols.
  localparam int unsigned DefMaxChars = 1024;

  // Fixed widths of the item fields.
  localparam int unsigned ActW   = 2;
  localparam int unsigned SymW   = 2;
  localparam int unsigned StatW  = 2;
  localparam int unsigned FieldW = 11;

  typedef enum logic [ActW-1:0] {
    ACT_APPEND = 2'd0,
    ACT_QUERY  = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [StatW-1:0] {
    ST_OK      = 2'd0,
    ST_NOMATCH = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [4:0] {
    OP_NOP         = 5'd0,
    OP_INIT        = 5'd1,
    OP_OUT_CLEAR   = 5'd2,
    OP_OUT_FULL    = 5'd3,
    OP_OUT_NONE    = 5'd4,
    OP_OUT_NOMATCH = 5'd5,
    OP_A_START     = 5'd6,
    OP_A_NEW       = 5'd7,
    OP_WALK_SET    = 5'd8,
    OP_WALK_HIT    = 5'd9,
    OP_LINK_Q      = 5'd10,
    OP_CLONE       = 5'd11,
    OP_CL_CUR      = 5'd12,
    OP_CL_Q        = 5'd13,
    OP_REDIR_SET   = 5'd14,
    OP_A_FIN       = 5'd15,
    OP_Q_START     = 5'd16,
    OP_Q_STEP      = 5'd17,
    OP_Q_FIN       = 5'd18
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic query_none;
    logic edge_absent;
    logic link_zero;
    logic len_match;
    logic redir_go;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/sabm_ctrl.sv */
// ----------------------------------------------------------------------------
// sabm_ctrl
// Controller state machine: sequences appends, query steps, clears and the other action codes.
// ----------------------------------------------------------------------------
`default_nettype none

module sabm_ctrl (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     s_valid_i,
  input  wire  [1:0]              s_action_i,
  output logic                    s_ready_o,
  input  sabm_pkg::dp_stat_t      stat_i,
  output sabm_pkg::dp_cmd_t       cmd_o
);
  import sabm_pkg::*;

  typedef enum logic [10:0] {
    S_INIT   = 11'b000_0000_0001,
    S_IDLE   = 11'b000_0000_0010,
    S_A_NEW  = 11'b000_0000_0100,
    S_WALK   = 11'b000_0000_1000,
    S_CHKQ   = 11'b000_0001_0000,
    S_CL_CUR = 11'b000_0010_0000,
    S_CL_Q   = 11'b000_0100_0000,
    S_REDIR  = 11'b000_1000_0000,
    S_A_FIN  = 11'b001_0000_0000,
    S_Q_STEP = 11'b010_0000_0000,
    S_Q_FIN  = 11'b100_0000_0000
  } state_e;

  state_e  state_q, state_d;
  action_e action;

  assign action = action_e'(s_action_i);

  // Next state and command decode.
  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NOP;
    s_ready_o = 1'b0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.op = OP_INIT;
        state_d  = S_IDLE;
      end
      S_IDLE: begin
        s_ready_o = stat_i.out_free;
        if (s_valid_i && stat_i.out_free) begin
          unique case (action)
            ACT_APPEND: begin
              if (stat_i.full) begin
                cmd_o.op = OP_OUT_FULL;
              end else begin
                cmd_o.op = OP_A_START;
                state_d  = S_A_NEW;
              end
            end
            ACT_QUERY: begin
              if (stat_i.query_none) begin
                cmd_o.op = OP_OUT_NOMATCH;
              end else begin
                cmd_o.op = OP_Q_START;
                state_d  = S_Q_STEP;
              end
            end
            ACT_CLEAR: begin
              cmd_o.op = OP_OUT_CLEAR;
              state_d  = S_INIT;
            end
            default: cmd_o.op = OP_OUT_NONE;
          endcase
        end
      end
      S_A_NEW: begin
        cmd_o.op = OP_A_NEW;
        state_d  = S_WALK;
      end
      S_WALK: begin
        if (stat_i.edge_absent) begin
          cmd_o.op = OP_WALK_SET;
          if (stat_i.link_zero) state_d = S_A_FIN;
        end else begin
          cmd_o.op = OP_WALK_HIT;
          state_d  = S_CHKQ;
        end
      end
      S_CHKQ: begin
        if (stat_i.len_match) begin
          cmd_o.op = OP_LINK_Q;
          state_d  = S_A_FIN;
        end else begin
          cmd_o.op = OP_CLONE;
          state_d  = S_CL_CUR;
        end
      end
      S_CL_CUR: begin
        cmd_o.op = OP_CL_CUR;
        state_d  = S_CL_Q;
      end
      S_CL_Q: begin
        cmd_o.op = OP_CL_Q;
        state_d  = S_REDIR;
      end
      S_REDIR: begin
        if (stat_i.redir_go) begin
          cmd_o.op = OP_REDIR_SET;
          if (stat_i.link_zero) state_d = S_A_FIN;
        end else begin
          state_d = S_A_FIN;
        end
      end
      S_A_FIN: begin
        cmd_o.op = OP_A_FIN;
        state_d  = S_IDLE;
      end
      S_Q_STEP: begin
        cmd_o.op = OP_Q_STEP;
        state_d  = stat_i.edge_absent ? S_IDLE : S_Q_FIN;
      end
      S_Q_FIN: begin
        cmd_o.op = OP_Q_FIN;
        state_d  = S_IDLE;
      end
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/sabm_dp.sv */
// ----------------------------------------------------------------------------
// sabm_dp
// Datapath: node tables, build and query registers, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sabm_dp #(
  parameter int unsigned MaxChars = sabm_pkg::DefMaxChars
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  sabm_pkg::dp_cmd_t            cmd_i,
  output sabm_pkg::dp_stat_t           stat_o,
  input  wire  [sabm_pkg::SymW-1:0]    in_sym_i,
  input  wire                          in_qstart_i,
  output logic                         m_valid_o,
  input  wire                          m_ready_i,
  output logic [sabm_pkg::StatW-1:0]   m_status_o,
  output logic [sabm_pkg::FieldW-1:0]  m_node_o,
  output logic [sabm_pkg::FieldW-1:0]  m_len_o,
  output logic [sabm_pkg::FieldW-1:0]  m_count_o
);
  import sabm_pkg::*;

  localparam int unsigned NodeCap = 2 * MaxChars;
  localparam int unsigned NW      = $clog2(NodeCap);
  localparam int unsigned CW      = $clog2(MaxChars + 1);
  localparam logic [NW-1:0] Root  = NW'(1);

  typedef logic [3:0][NW-1:0] row_t;

  // Node tables: one transition row, suffix link and length per node.
  row_t          trans_mem [NodeCap];
  logic [NW-1:0] link_mem  [NodeCap];
  logic [CW-1:0] len_mem   [NodeCap];

  row_t          trans_rd;
  logic [NW-1:0] link_rd;
  logic [CW-1:0] len_rd;

  logic          t_we, l_we, n_we, rd_en;
  logic [NW-1:0] t_wa, l_wa, n_wa, rd_addr;
  row_t          t_wd;
  logic [NW-1:0] l_wd;
  logic [CW-1:0] n_wd;

  logic [NW-1:0] last_q, last_d, used_q, used_d, cursor_q, cursor_d;
  logic [CW-1:0] chars_q, chars_d;
  logic [NW-1:0] cur_q, cur_d, cl_q, cl_d, p_q, p_d, q_q, q_d;
  logic [CW-1:0] plen_q, plen_d, cur_len_q, cur_len_d;
  logic [SymW-1:0] sym_q, sym_d;

  logic           out_valid_q, out_valid_d, out_load;
  status_e        o_status, out_status_q;
  logic [NW-1:0]  o_node, out_node_q, o_count, out_count_q;
  logic [CW-1:0]  o_len, out_len_q;
  logic [NW-1:0]  edge_rd;

  assign edge_rd = trans_rd[sym_q];

  // Branch flags for the controller.
  assign stat_o.full        = (chars_q >= CW'(MaxChars));
  assign stat_o.query_none  = !in_qstart_i && (cursor_q == '0);
  assign stat_o.edge_absent = (edge_rd == '0);
  assign stat_o.link_zero   = (link_rd == '0);
  assign stat_o.len_match   = (len_rd == plen_q + CW'(1));
  assign stat_o.redir_go    = (edge_rd == q_q);
  assign stat_o.out_free    = !out_valid_q || m_ready_i;

  // Per-operation table access and register updates.
  always_comb begin
    last_d    = last_q;
    used_d    = used_q;
    cursor_d  = cursor_q;
    chars_d   = chars_q;
    cur_d     = cur_q;
    cl_d      = cl_q;
    p_d       = p_q;
    q_d       = q_q;
    plen_d    = plen_q;
    cur_len_d = cur_len_q;
    sym_d     = sym_q;
    t_we      = 1'b0;
    t_wa      = cur_q;
    t_wd      = '0;
    l_we      = 1'b0;
    l_wa      = cur_q;
    l_wd      = '0;
    n_we      = 1'b0;
    n_wa      = cur_q;
    n_wd      = '0;
    rd_en     = 1'b0;
    rd_addr   = p_q;
    out_load  = 1'b0;
    o_status  = ST_OK;
    o_node    = '0;
    o_len     = '0;
    o_count   = used_q;
    unique case (cmd_i.op)
      OP_INIT: begin
        t_we     = 1'b1;
        t_wa     = Root;
        l_we     = 1'b1;
        l_wa     = Root;
        n_we     = 1'b1;
        n_wa     = Root;
        last_d   = Root;
        used_d   = Root;
        chars_d  = '0;
        cursor_d = Root;
      end
      OP_OUT_CLEAR: begin
        out_load = 1'b1;
        o_count  = Root;
      end
      OP_OUT_FULL: begin
        out_load = 1'b1;
        o_status = ST_FULL;
      end
      OP_OUT_NONE: out_load = 1'b1;
      OP_OUT_NOMATCH: begin
        out_load = 1'b1;
        o_status = ST_NOMATCH;
      end
      OP_A_START: begin
        sym_d   = in_sym_i;
        p_d     = last_q;
        cur_d   = used_q + NW'(1);
        used_d  = used_q + NW'(1);
        rd_en   = 1'b1;
        rd_addr = last_q;
      end
      OP_A_NEW: begin
        t_we      = 1'b1;
        n_we      = 1'b1;
        n_wd      = len_rd + CW'(1);
        cur_len_d = len_rd + CW'(1);
      end
      OP_WALK_SET: begin
        t_we        = 1'b1;
        t_wa        = p_q;
        t_wd        = trans_rd;
        t_wd[sym_q] = cur_q;
        p_d         = link_rd;
        if (link_rd == '0) begin
          l_we = 1'b1;
          l_wd = Root;
        end else begin
          rd_en   = 1'b1;
          rd_addr = link_rd;
        end
      end
      OP_WALK_HIT: begin
        q_d     = edge_rd;
        plen_d  = len_rd;
        rd_en   = 1'b1;
        rd_addr = edge_rd;
      end
      OP_LINK_Q: begin
        l_we = 1'b1;
        l_wd = q_q;
      end
      OP_CLONE: begin
        cl_d   = used_q + NW'(1);
        used_d = used_q + NW'(1);
        t_we   = 1'b1;
        t_wa   = used_q + NW'(1);
        t_wd   = trans_rd;
        l_we   = 1'b1;
        l_wa   = used_q + NW'(1);
        l_wd   = link_rd;
        n_we   = 1'b1;
        n_wa   = used_q + NW'(1);
        n_wd   = plen_q + CW'(1);
      end
      OP_CL_CUR: begin
        l_we = 1'b1;
        l_wd = cl_q;
      end
      OP_CL_Q: begin
        l_we    = 1'b1;
        l_wa    = q_q;
        l_wd    = cl_q;
        rd_en   = 1'b1;
        rd_addr = p_q;
      end
      OP_REDIR_SET: begin
        t_we        = 1'b1;
        t_wa        = p_q;
        t_wd        = trans_rd;
        t_wd[sym_q] = cl_q;
        p_d         = link_rd;
        if (link_rd != '0) begin
          rd_en   = 1'b1;
          rd_addr = link_rd;
        end
      end
      OP_A_FIN: begin
        out_load = 1'b1;
        o_node   = cur_q;
        o_len    = cur_len_q;
        last_d   = cur_q;
        chars_d  = chars_q + CW'(1);
      end
      OP_Q_START: begin
        sym_d   = in_sym_i;
        rd_en   = 1'b1;
        rd_addr = in_qstart_i ? Root : cursor_q;
      end
      OP_Q_STEP: begin
        cursor_d = edge_rd;
        if (edge_rd == '0) begin
          out_load = 1'b1;
          o_status = ST_NOMATCH;
        end else begin
          rd_en   = 1'b1;
          rd_addr = edge_rd;
        end
      end
      OP_Q_FIN: begin
        out_load = 1'b1;
        o_node   = cursor_q;
        o_len    = len_rd;
      end
      default: ;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !m_ready_i);

  // Table memories with registered read data.
  always_ff @(posedge clk_i) begin
    if (t_we) trans_mem[t_wa] <= t_wd;
    if (rd_en) trans_rd <= trans_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (l_we) link_mem[l_wa] <= l_wd;
    if (rd_en) link_rd <= link_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (n_we) len_mem[n_wa] <= n_wd;
    if (rd_en) len_rd <= len_mem[rd_addr];
  end

  // Automaton bookkeeping and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= Root;
      used_q      <= Root;
      cursor_q    <= Root;
      chars_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      last_q      <= last_d;
      used_q      <= used_d;
      cursor_q    <= cursor_d;
      chars_q     <= chars_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers and result payload.
  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    cl_q      <= cl_d;
    p_q       <= p_d;
    q_q       <= q_d;
    plen_q    <= plen_d;
    cur_len_q <= cur_len_d;
    sym_q     <= sym_d;
    if (out_load) begin
      out_status_q <= o_status;
      out_node_q   <= o_node;
      out_len_q    <= o_len;
      out_count_q  <= o_count;
    end
  end

  assign m_valid_o  = out_valid_q;
  assign m_status_o = out_status_q;
  assign m_node_o   = FieldW'(out_node_q);
  assign m_len_o    = FieldW'(out_len_q);
  assign m_count_o  = FieldW'(out_count_q);

`include "suffix_automaton_build_match_assert.svh"

  `SABM_ASSERT(a_no_null_write, !t_we || (t_wa != '0), "transition write to null node")
  `SABM_ASSERT(a_chars_cap, chars_q <= CW'(MaxChars), "symbol count beyond capacity")
  `SABM_ASSERT(a_load_free, !out_load || !out_valid_q || m_ready_i, "result overwritten")
  `SABM_ASSERT_NEXT(a_fin_count, cmd_i.op == OP_A_FIN,
                    chars_q == $past(chars_q) + CW'(1), "append not counted")

endmodule

`default_nettype wire

/* rtl/suffix_automaton_build_match.sv */
// Sequence: an append runs start, new node, a walk over transition sets, then finish
//   at the root or a length check; a clone adds clone, cur-link, q-link and redirect;
//   a query runs start, step and finish, or stops at the step on a miss; a dead cursor and
//   other actions answer from idle, clear then via init; the result is registered.
// Throughput: one item at a time, bounded by the single read port of the tables.
// Reset: root node set up in 1 cycle after reset or clear; ready low meanwhile.
// ----------------------------------------------------------------------------
// suffix_automaton_build_match
// Online suffix automaton over a four-letter alphabet with substring query.
// ----------------------------------------------------------------------------
`default_nettype none

module suffix_automaton_build_match #(
  parameter int unsigned MaxChars = sabm_pkg::DefMaxChars
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // symbol [1:0], query_start [2]
  input  wire  [1:0]  s_axis_tuser,   // action [1:0]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata,   // node [10:0], node_len [21:11], node_count [32:22]
  output logic [1:0]  m_axis_tuser    // status [1:0]
);
  import sabm_pkg::*;

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic [FieldW-1:0]  node, node_len, node_count;

  sabm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_action_i (s_axis_tuser),
    .s_ready_o  (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sabm_dp #(
    .MaxChars (MaxChars)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_sym_i    (s_axis_tdata[1:0]),
    .in_qstart_i (s_axis_tdata[2]),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_status_o  (m_axis_tuser),
    .m_node_o    (node),
    .m_len_o     (node_len),
    .m_count_o   (node_count)
  );

  // Pack the result item.
  assign m_axis_tdata = {7'b0, node_count, node_len, node};

endmodule

`default_nettype wire

/* tb/sv/suffix_automaton_build_match_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suffix_automaton_build_match_chk
// Watches both streams of the suffix automaton block, keeps its own copy of
// the automaton, predicts the result of every accepted item and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module suffix_automaton_build_match_chk #(
  parameter int unsigned MaxChars = sabm_pkg::DefMaxChars
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  input  wire         s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // symbol [1:0], query_start [2]
  input  wire  [1:0]  s_axis_tuser,   // action [1:0]
  input  wire         m_axis_tvalid,
  input  wire         m_axis_tready,
  input  wire  [39:0] m_axis_tdata,   // node [10:0], node_len [21:11], node_count [32:22]
  input  wire  [1:0]  m_axis_tuser,   // status [1:0]
  output int          fail_count_o,
  output int          pending_o
);
  import sabm_pkg::*;

  localparam int unsigned NodeCap = 2 * MaxChars;
  localparam int unsigned Root    = 1;

  typedef struct packed {
    status_e      status;
    logic [10:0]  node;
    logic [10:0]  node_len;
    logic [10:0]  node_count;
  } sam_result_t;

  // Model copy of the automaton tables and registers.
  logic [10:0]  edge_tab [NodeCap][4];
  logic [10:0]  link_tab [NodeCap];
  logic [10:0]  len_tab  [NodeCap];
  int unsigned  tail_node;
  int unsigned  used_nodes;
  int unsigned  text_len;
  int unsigned  cursor;

  sam_result_t  result_q [$];
  int           fails;

  assign fail_count_o = fails;
  assign pending_o    = result_q.size();

  function automatic int unsigned wrap_node(input int unsigned n);
    return (n < NodeCap) ? n : 0;
  endfunction

  function automatic void wipe_automaton();
    for (int i = 0; i < NodeCap; i++) begin
      link_tab[i] = '0;
      len_tab[i]  = '0;
      for (int k = 0; k < 4; k++) edge_tab[i][k] = '0;
    end
    tail_node  = Root;
    used_nodes = 1;
    text_len   = 0;
    cursor     = Root;
  endfunction

  // Online extension by one symbol, cloning when the length test fails.
  function automatic int unsigned extend_text(input logic [1:0] c);
    int unsigned cur;
    int unsigned p;
    int unsigned q;
    int unsigned cl;
    cur = wrap_node(used_nodes + 1);
    p   = wrap_node(tail_node);
    used_nodes    = cur;
    len_tab[cur]  = len_tab[p] + 11'd1;
    link_tab[cur] = '0;
    for (int k = 0; k < 4; k++) edge_tab[cur][k] = '0;
    while (p != 0 && edge_tab[p][c] == 0) begin
      edge_tab[p][c] = cur[10:0];
      p = wrap_node(link_tab[p]);
    end
    if (p == 0) begin
      link_tab[cur] = Root[10:0];
    end else begin
      q = wrap_node(edge_tab[p][c]);
      if (int'(len_tab[q]) == int'(len_tab[p]) + 1) begin
        link_tab[cur] = q[10:0];
      end else begin
        cl = wrap_node(used_nodes + 1);
        used_nodes = cl;
        for (int k = 0; k < 4; k++) edge_tab[cl][k] = edge_tab[q][k];
        link_tab[cl]  = link_tab[q];
        len_tab[cl]   = len_tab[p] + 11'd1;
        link_tab[cur] = cl[10:0];
        link_tab[q]   = cl[10:0];
        while (p != 0 && edge_tab[p][c] == q[10:0]) begin
          edge_tab[p][c] = cl[10:0];
          p = wrap_node(link_tab[p]);
        end
      end
    end
    tail_node = cur;
    text_len++;
    return cur;
  endfunction

  function automatic sam_result_t predict_step(input logic [1:0] act, input logic [1:0] sym,
                                               input logic qs);
    sam_result_t r;
    int unsigned nd;
    r.status = ST_OK;
    r.node = '0;
    r.node_len = '0;
    case (act)
      ACT_APPEND: begin
        if (text_len >= MaxChars) begin
          r.status = ST_FULL;
        end else begin
          nd = extend_text(sym);
          r.node = nd[10:0];
          r.node_len = len_tab[nd];
        end
      end
      ACT_QUERY: begin
        if (qs) cursor = Root;
        if (cursor != 0) cursor = wrap_node(edge_tab[wrap_node(cursor)][sym]);
        if (cursor == 0) begin
          r.status = ST_NOMATCH;
        end else begin
          r.node = cursor[10:0];
          r.node_len = len_tab[cursor];
        end
      end
      ACT_CLEAR: begin
        wipe_automaton();
      end
      default: ;
    endcase
    r.node_count = used_nodes[10:0];
    return r;
  endfunction

  // Input side: predict on every accepted item.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wipe_automaton();
      result_q.delete();
    end else if (s_axis_tvalid && s_axis_tready) begin
      result_q.insert(result_q.size(),
                      predict_step(s_axis_tuser, s_axis_tdata[1:0], s_axis_tdata[2]));
    end
  end

  // Output side: compare every accepted item with the oldest prediction.
  initial fails = 0;
  always @(posedge clk_i) begin
    sam_result_t exp_r;
    sam_result_t got_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_r.status     = status_e'(m_axis_tuser);
      got_r.node       = m_axis_tdata[10:0];
      got_r.node_len   = m_axis_tdata[21:11];
      got_r.node_count = m_axis_tdata[32:22];
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d node=%0d len=%0d count=%0d", $time,
                 got_r.status, got_r.node, got_r.node_len, got_r.node_count);
        fails++;
      end else begin
        exp_r = result_q.pop_front();
        if (got_r != exp_r) begin
          $display("%0t: mismatch expected status=%0d node=%0d len=%0d count=%0d", $time,
                   exp_r.status, exp_r.node, exp_r.node_len, exp_r.node_count);
          $display("%0t:          actual   status=%0d node=%0d len=%0d count=%0d", $time,
                   got_r.status, got_r.node, got_r.node_len, got_r.node_count);
          fails++;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* tb/sv/suffix_automaton_build_match_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suffix_automaton_build_match_tb
// Drives appends, query runs, clears and idle codes into the suffix automaton with random
// gaps on both streams; the checker beside the block judges every result.
// ----------------------------------------------------------------------------
`default_nettype none

module suffix_automaton_build_match_tb;
  import sabm_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  int          fail_count;
  int          pending;
  bit          no_gaps;

  suffix_automaton_build_match dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  suffix_automaton_build_match_chk chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("FAIL");
    $finish;
  end

  // Sends one item; inputs change only at the falling edge, and the
  // handshake is judged at the rising edge.
  task automatic send_item(input action_e act, input logic [1:0] sym, input logic qs);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = act;
    s_axis_tdata  = {5'b0, qs, sym};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Result side: random stall before each item.
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      gap = no_gaps ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        m_axis_tready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      while (!m_axis_tvalid) @(negedge clk_i);
    end
  end

  initial begin
    int pick;
    int waited;
    logic [1:0] sym;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_APPEND;
    no_gaps       = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty query, a text that forces a clone, matches and misses.
    send_item(ACT_QUERY, 2'd0, 1'b1);
    send_item(ACT_APPEND, 2'd0, 1'b0);
    send_item(ACT_APPEND, 2'd1, 1'b0);
    send_item(ACT_APPEND, 2'd1, 1'b1);
    send_item(ACT_APPEND, 2'd2, 1'b0);
    send_item(ACT_APPEND, 2'd3, 1'b0);
    send_item(ACT_QUERY, 2'd0, 1'b1);
    send_item(ACT_QUERY, 2'd1, 1'b0);
    send_item(ACT_QUERY, 2'd1, 1'b0);
    send_item(ACT_QUERY, 2'd2, 1'b0);
    send_item(ACT_QUERY, 2'd3, 1'b0);
    send_item(ACT_QUERY, 2'd0, 1'b0);
    send_item(ACT_QUERY, 2'd1, 1'b0);
    send_item(ACT_QUERY, 2'd1, 1'b1);
    send_item(ACT_NONE, 2'd3, 1'b1);
    send_item(ACT_CLEAR, 2'd2, 1'b1);
    send_item(ACT_QUERY, 2'd1, 1'b1);
    send_item(ACT_APPEND, 2'd3, 1'b0);

    // Fill the text to capacity, then push appends past it.
    for (int i = 0; i < 1030; i++) begin
      if (i % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      sym = (i < 600) ? 2'($urandom_range(0, 1)) : 2'($urandom_range(0, 3));
      send_item(ACT_APPEND, sym, 1'($urandom_range(0, 1)));
    end
    for (int i = 0; i < 30; i++) send_item(ACT_QUERY, 2'($urandom_range(0, 3)), i % 8 == 0);
    send_item(ACT_CLEAR, 2'd0, 1'b0);

    // Random mix: query runs from the root, appends, rare clears and idle codes.
    for (int i = 0; i < 30; i++) begin
      if (i % 10 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      sym  = 2'($urandom_range(0, 3));
      if (pick < 50)      send_item(ACT_APPEND, sym, 1'($urandom_range(0, 1)));
      else if (pick < 90) send_item(ACT_QUERY, sym, $urandom_range(0, 5) == 0);
      else if (pick < 95) send_item(ACT_CLEAR, sym, 1'($urandom_range(0, 1)));
      else                send_item(ACT_NONE, sym, 1'($urandom_range(0, 1)));
    end
    s_axis_tvalid = 1'b0;

    waited = 0;
    while (pending != 0 && waited < 100000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (50) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
